@@ design/kscan_pkg.sv @@
// Shared types and constants for the key scanner.
// Used by kscan_ctrl, kscan_dp and key_scan_debounce_long_press; no dependencies.
package kscan_pkg;

  localparam int NUM_KEYS_DEF    = 6;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MASK_KEYS       = 6;    // keys that have a pin bit
  localparam int LIMIT_W         = 16;
  localparam int CODE_W          = 3;
  localparam int INDEX_W         = 3;
  localparam int MASK_W          = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  // per-key debounce phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIP = 3'd1,
    PH_DOWN = 3'd2,
    PH_HELD = 3'd3,
    PH_REST = 3'd4
  } phase_t;

  typedef struct packed {
    logic activate;    // append key_index to the active list
    logic scan_start;  // latch pin states, snapshot list length
    logic step;        // step one listed key
    logic finish;      // commit compacted list length
    logic drain_read;  // read oldest queue entry
    logic load;        // pop entry into output register
  } cmd_t;

  typedef struct packed {
    logic step_done;   // every snapshot key visited
    logic q_nonempty;
    logic drain_full;  // per-scan result limit reached
  } status_t;

endpackage

@@ design/kscan_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kscan_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/kscan_ctrl.sv @@
// Sequencer for the key scanner: accept, per-key stepping, queue drain.
// Depends on kscan_pkg.
module kscan_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               req_type,
  input  logic               out_stall,
  input  kscan_pkg::status_t status,
  output logic               in_stall,
  output logic               out_valid,
  output kscan_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_LOAD  = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type) begin
            cmd.scan_start = 1'b1;
            state_next     = S_STEP;
          end else begin
            cmd.activate = 1'b1;
          end
        end
      end
      S_STEP: begin
        if (status.step_done) begin
          cmd.finish = 1'b1;
          state_next = S_DRAIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DRAIN: begin
        if (status.q_nonempty && !status.drain_full) begin
          cmd.drain_read = 1'b1;
          state_next     = S_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          state_next = S_DRAIN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SEND);

endmodule

@@ design/kscan_dp.sv @@
// Key scanner datapath: key phases, hold counters, active list, event queue.
// Depends on kscan_pkg and kscan_ram.
module kscan_dp #(
  parameter int NUM_KEYS    = kscan_pkg::NUM_KEYS_DEF,
  parameter int QUEUE_DEPTH = kscan_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kscan_pkg::cmd_t                cmd,
  input  logic [kscan_pkg::INDEX_W-1:0]  key_index,
  input  logic [kscan_pkg::MASK_W-1:0]   pressed_mask,
  input  logic                           cfg_we,
  input  logic [kscan_pkg::LIMIT_W-1:0]  cfg_data,
  output kscan_pkg::status_t             status,
  output logic [kscan_pkg::CODE_W-1:0]   key_code,
  output logic                           last
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int LW = kscan_pkg::LIMIT_W;

  kscan_pkg::phase_t key_phase [NUM_KEYS];
  logic [LW-1:0]     hold_count [NUM_KEYS];
  logic [NUM_KEYS-1:0] key_active;
  logic [KW-1:0]     active_order [NUM_KEYS];
  logic [CW-1:0]     active_count;
  logic [LW-1:0]     long_press_limit;

  logic [kscan_pkg::MASK_W-1:0] mask;
  logic [CW-1:0] scan_n, scan_i, scan_j, drain_cnt;

  logic [QW-1:0] q_wr, q_rd;
  logic          q_nonempty;
  logic [QW-1:0] wr_inc, rd_inc;
  logic [kscan_pkg::CODE_W-1:0] q_rdata;

  // activate decode
  logic [KW-1:0] act_key;
  logic          act_ok;

  assign act_key = KW'(key_index);
  assign act_ok  = (32'(key_index) < NUM_KEYS) && !key_active[act_key] &&
                   (32'(active_count) < NUM_KEYS);

  // one key step
  logic [KW-1:0]     cur_key;
  kscan_pkg::phase_t cur_phase, ph_next;
  logic [LW-1:0]     cur_hold, hold_next;
  logic [LW:0]       hold_inc;
  logic [7:0]        mask_ext;
  logic              pressed, hold_we, keep, push;

  assign cur_key   = active_order[scan_i[KW-1:0]];
  assign cur_phase = key_phase[cur_key];
  assign cur_hold  = hold_count[cur_key];
  assign mask_ext  = {2'b00, mask};
  assign pressed   = (32'(cur_key) < kscan_pkg::MASK_KEYS) && mask_ext[3'(cur_key)];
  assign hold_inc  = {1'b0, cur_hold} + (LW+1)'(1);

  always_comb begin
    ph_next   = cur_phase;
    hold_next = cur_hold;
    hold_we   = 1'b0;
    keep      = 1'b1;
    push      = 1'b0;
    unique case (cur_phase)
      kscan_pkg::PH_IDLE: ph_next = pressed ? kscan_pkg::PH_TRIP : kscan_pkg::PH_REST;
      kscan_pkg::PH_TRIP: ph_next = pressed ? kscan_pkg::PH_DOWN : kscan_pkg::PH_REST;
      kscan_pkg::PH_DOWN: begin
        if (pressed) begin
          ph_next   = kscan_pkg::PH_HELD;
          hold_next = '0;
          hold_we   = 1'b1;
        end else begin
          ph_next = kscan_pkg::PH_REST;
        end
      end
      kscan_pkg::PH_HELD: begin
        if (!pressed) begin
          push    = 1'b1;
          keep    = 1'b0;
          ph_next = kscan_pkg::PH_IDLE;
        end else if (hold_inc > {1'b0, long_press_limit}) begin
          hold_next = long_press_limit;   // saturate and repeat
          hold_we   = 1'b1;
          push      = 1'b1;
        end else begin
          hold_next = hold_inc[LW-1:0];
          hold_we   = 1'b1;
        end
      end
      default: begin
        keep    = 1'b0;
        ph_next = kscan_pkg::PH_IDLE;
      end
    endcase
  end

  assign wr_inc = (q_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : q_wr + 1'b1;
  assign rd_inc = (q_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : q_rd + 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_phase[k] <= kscan_pkg::PH_IDLE;
      end
      key_active       <= '0;
      active_count     <= '0;
      long_press_limit <= kscan_pkg::LIMIT_RESET;
      scan_n           <= '0;
      scan_i           <= '0;
      scan_j           <= '0;
      drain_cnt        <= '0;
      q_wr             <= '0;
      q_rd             <= '0;
      q_nonempty       <= 1'b0;
    end else begin
      if (cfg_we) begin
        long_press_limit <= cfg_data;
      end
      if (cmd.activate && act_ok) begin
        key_active[act_key] <= 1'b1;
        active_count        <= active_count + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_n    <= active_count;
        scan_i    <= '0;
        scan_j    <= '0;
        drain_cnt <= '0;
      end
      if (cmd.step) begin
        scan_i             <= scan_i + 1'b1;
        key_phase[cur_key] <= ph_next;
        if (keep) begin
          scan_j <= scan_j + 1'b1;
        end else begin
          key_active[cur_key] <= 1'b0;
        end
        if (push) begin
          q_wr       <= wr_inc;
          q_nonempty <= 1'b1;
          if (wr_inc == q_rd) begin
            q_rd <= rd_inc;   // full: drop oldest
          end
        end
      end
      if (cmd.finish) begin
        active_count <= scan_j;
      end
      if (cmd.load) begin
        q_rd      <= rd_inc;
        drain_cnt <= drain_cnt + 1'b1;
        if (rd_inc == q_wr) begin
          q_nonempty <= 1'b0;
        end
      end
    end
  end

  // payload: list entries, counters, pin latch, output register
  always_ff @(posedge clk) begin
    if (cmd.activate && act_ok) begin
      active_order[active_count[KW-1:0]] <= act_key;
    end
    if (cmd.scan_start) begin
      mask <= pressed_mask;
    end
    if (cmd.step) begin
      if (hold_we) begin
        hold_count[cur_key] <= hold_next;
      end
      if (keep) begin
        active_order[scan_j[KW-1:0]] <= cur_key;   // in-place compaction
      end
    end
    if (cmd.load) begin
      key_code <= q_rdata;
      last     <= (rd_inc == q_wr) || (drain_cnt == CW'(NUM_KEYS - 1));
    end
  end

  kscan_ram #(
    .WIDTH (kscan_pkg::CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.step && push),
    .waddr (q_wr),
    .wdata (kscan_pkg::CODE_W'(cur_key)),
    .re    (cmd.drain_read),
    .raddr (q_rd),
    .rdata (q_rdata)
  );

  assign status.step_done  = (scan_i == scan_n);
  assign status.q_nonempty = q_nonempty;
  assign status.drain_full = (drain_cnt == CW'(NUM_KEYS));

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    32'(active_count) <= NUM_KEYS)
    else $error("active list longer than key count");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    scan_j <= scan_i)
    else $error("list write index passed read index");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> q_nonempty)
    else $error("pop from empty event queue");

  a_push_sets_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && push) |=> q_nonempty)
    else $error("queue empty right after push");

endmodule

@@ design/key_scan_debounce_long_press.sv @@
// Key scanner top: debounce, long-press repeat, overwrite-oldest event queue.
// Activate item: taken in the idle state, next item accepted the following cycle.
// Scan item: accept, a step for each listed key, a commit and a queue check, plus for each
//   reported event a queue RAM read, output load and handoff; a stalled handoff waits.
// One item in flight: in_stall holds off new items until the controller is back in idle.
// Reset (rst, synchronous, active high): all keys idle and inactive, list and queue empty,
//   long_press_limit back to 100.
// Depends on kscan_pkg, kscan_ctrl, kscan_dp, kscan_ram.
module key_scan_debounce_long_press #(
  parameter int NUM_KEYS    = kscan_pkg::NUM_KEYS_DEF,
  parameter int QUEUE_DEPTH = kscan_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [kscan_pkg::INDEX_W-1:0] key_index,
  input  logic [kscan_pkg::MASK_W-1:0]  pressed_mask,
  // result item channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kscan_pkg::CODE_W-1:0]  key_code,
  output logic                          last,
  // long_press_limit write port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kscan_pkg::LIMIT_W-1:0] cfg_data
);

  kscan_pkg::cmd_t    cmd;
  kscan_pkg::status_t status;

  // register writes must arrive only while idle; the block does not enforce it (cfg_ready is tied high)
  assign cfg_ready = 1'b1;

  // controller: owns the input and result handshakes and sequences the datapath
  kscan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath: key state, active list, event queue and output register;
  // key_code/last stay registered while a result item is stalled
  kscan_dp #(
    .NUM_KEYS    (NUM_KEYS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key_index    (key_index),
    .pressed_mask (pressed_mask),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .status       (status),
    .key_code     (key_code),
    .last         (last)
  );

endmodule
